@@ sv/double_ended_queue_top_assert.svh @@
// assertion macros for the double-ended queue
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// condition now implies consequence in the following cycle
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("double_ended_queue: next-cycle check failed");

// condition now implies consequence in the same cycle
`define DQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("double_ended_queue: same-cycle check failed");

`endif

@@ sv/dq_pkg.sv @@
package dq_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_CLEAR      = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam int OPCODE_W = 3;

endpackage

@@ sv/dq_ring_mem.sv @@
module dq_ring_mem
   import dq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/dq_ctrl.sv @@
module dq_ctrl
   import dq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = 4,
   parameter int CNT_W      = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [OPCODE_W-1:0]   opcode,
   input  logic [DATA_WIDTH-1:0] data_in,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [DATA_WIDTH-1:0] wr_data,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   output status_type            status,
   output logic                  rd_ok,
   output logic [CNT_W-1:0]      count
);

   logic [AW-1:0]    front_ff, front_in;
   logic [AW-1:0]    back_ff, back_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       status_ff, status_in;
   logic             rd_ok_ff, rd_ok_in;
   logic [AW-1:0]    front_prev, front_next, back_prev, back_next;
   logic             full, empty;

   // ring wrap for any depth
   assign front_prev = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - 1'b1;
   assign front_next = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign back_prev  = (back_ff == '0) ? AW'(DEPTH - 1) : back_ff - 1'b1;
   assign back_next  = (back_ff == AW'(DEPTH - 1)) ? '0 : back_ff + 1'b1;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   assign wr_data = data_in;

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      rd_ok_in  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = front_prev;
      rd_en     = 1'b0;
      rd_addr   = front_ff;
      if (accept) begin
         unique case (opcode)
            OP_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = front_prev;
                  front_in = front_prev;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = back_ff;
                  back_in  = back_next;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_ok_in = 1'b1;
                  rd_addr  = front_ff;
                  front_in = front_next;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_ok_in = 1'b1;
                  rd_addr  = back_prev;
                  back_in  = back_prev;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_PEEK_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_ok_in = 1'b1;
                  rd_addr  = front_ff;
               end
            end
            OP_PEEK_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_ok_in = 1'b1;
                  rd_addr  = back_prev;
               end
            end
            OP_CLEAR: begin
               front_in = '0;
               back_in  = '0;
               count_in = '0;
            end
            default: begin
               // undefined opcode: no change, status ok
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff  <= '0;
         back_ff   <= '0;
         count_ff  <= '0;
         status_ff <= ST_OK;
         rd_ok_ff  <= 1'b0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
         if (accept) begin
            status_ff <= status_in;
            rd_ok_ff  <= rd_ok_in;
         end
      end
   end

   assign status = status_ff;
   assign rd_ok  = rd_ok_ff;
   assign count  = count_ff;

endmodule

@@ sv/double_ended_queue_top.sv @@
// bounded double-ended queue of data words held in a ring memory
// input channel: an item is taken at a clock edge where start is high and
//   busy is low; req_opcode selects push front/back, pop front/back,
//   peek front/back or clear, req_data_in is the word stored by a push
// result channel: every item gives one result, shown for exactly one cycle
//   with rsp_valid high, in the cycle after the item is taken; it carries the
//   status (ok, empty, full), the popped or peeked word (zero unless a pop or
//   peek succeeded), the element count after the item and an empty flag
// throughput: one item per cycle while busy is low; the pointers and count
//   update at the accepting edge, where the registered read of the ring
//   memory also captures the end word, so consecutive items never collide
// busy is high during reset and in the first cycle after it is released
// reset (synchronous, active high) empties the queue and zeroes both
//   pointers; the memory contents are not cleared, only written slots are
//   ever read
// the receiver cannot stall: a result not taken in its cycle is gone
module double_ended_queue_top
   import dq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [OPCODE_W-1:0]           req_opcode,
   input  logic [DATA_WIDTH-1:0]         req_data_in,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [DATA_WIDTH-1:0]         rsp_data_out,
   output logic [$clog2(DEPTH + 1)-1:0]  rsp_count,
   output logic                          rsp_is_empty
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                  accept;
   logic                  busy_ff;
   logic                  rsp_valid_ff;
   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;
   status_type            status;
   logic                  rd_ok;
   logic [CNT_W-1:0]      count;

   assign accept = start & ~busy_ff;

   // hold off items for the first cycle out of reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
      end
   end

   dq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .opcode  (req_opcode),
      .data_in (req_data_in),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .status  (status),
      .rd_ok   (rd_ok),
      .count   (count)
   );

   dq_ring_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // word shows only for a successful pop or peek
   assign busy         = busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status;
   assign rsp_data_out = rd_ok ? rd_data : '0;
   assign rsp_count    = count;
   assign rsp_is_empty = (count == '0);

`include "double_ended_queue_top_assert.svh"

   `DQ_ASSERT_NEXT(a_result_follows_item, clock, reset, accept, rsp_valid)
   `DQ_ASSERT_NEXT(a_full_push_reports_full, clock, reset,
      accept && (count == CNT_W'(DEPTH)) &&
      (req_opcode == OP_PUSH_FRONT || req_opcode == OP_PUSH_BACK),
      rsp_status == ST_FULL && $stable(count))
   `DQ_ASSERT_NEXT(a_empty_read_reports_empty, clock, reset,
      accept && (count == '0) &&
      (req_opcode == OP_POP_FRONT || req_opcode == OP_POP_BACK ||
       req_opcode == OP_PEEK_FRONT || req_opcode == OP_PEEK_BACK),
      rsp_status == ST_EMPTY && rsp_data_out == '0)
   `DQ_ASSERT_NOW(a_count_in_range, clock, reset, rsp_valid,
      rsp_count <= CNT_W'(DEPTH))

endmodule
